// ----- rtl/rau_pkg.sv -----
package rau_pkg;

    localparam int WORD_BITS = 64;
    localparam int REGS      = 16;
    localparam int RIDX_BITS = $clog2(REGS);
    localparam int PC_BITS   = 5;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [RIDX_BITS-1:0] t_ridx;
    typedef logic [PC_BITS-1:0]   t_pc;
    typedef logic [3:0]           t_prog;

    // operation codes on the request channel
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_MOD = 3'd4;
    localparam logic [2:0] CMD_NEG = 3'd5;
    localparam logic [2:0] CMD_NOT = 3'd6;

    // microprogram selection: the command itself, or the zero divisor program
    localparam t_prog PROG_ADD = 4'd0;
    localparam t_prog PROG_SUB = 4'd1;
    localparam t_prog PROG_MUL = 4'd2;
    localparam t_prog PROG_DIV = 4'd3;
    localparam t_prog PROG_MOD = 4'd4;
    localparam t_prog PROG_NEG = 4'd5;
    localparam t_prog PROG_NOT = 4'd6;
    localparam t_prog PROG_DZ  = 4'd8;

    // scratch register file indexes
    localparam t_ridx R_AN = 4'd0;
    localparam t_ridx R_AD = 4'd1;
    localparam t_ridx R_BN = 4'd2;
    localparam t_ridx R_BD = 4'd3;
    localparam t_ridx R_G  = 4'd4;
    localparam t_ridx R_G2 = 4'd5;
    localparam t_ridx R_T0 = 4'd6;
    localparam t_ridx R_T1 = 4'd7;
    localparam t_ridx R_C  = 4'd8;
    localparam t_ridx R_Q  = 4'd9;
    localparam t_ridx R_RN = 4'd10;
    localparam t_ridx R_RD = 4'd11;

    typedef enum logic [3:0] {
        UOP_LD   = 4'd0,   // d = input word a
        UOP_ADD  = 4'd1,
        UOP_SUB  = 4'd2,
        UOP_NEG  = 4'd3,
        UOP_CNEG = 4'd4,   // d = b negative ? -a : a
        UOP_NOT  = 4'd5,
        UOP_SET0 = 4'd6,
        UOP_SET1 = 4'd7,
        UOP_MUL  = 4'd8,   // 64x8 per cycle
        UOP_GCD  = 4'd9,   // binary gcd, one step per cycle
        UOP_DIVM = 4'd10,  // signed a over magnitude b, zero b passes a
        UOP_SDIV = 4'd11,  // truncated signed divide, zero divisor gives 0
        UOP_OUT  = 4'd12   // a, b to the output register
    } t_uop_op;

    typedef struct packed {
        t_uop_op op;
        t_ridx   a;
        t_ridx   b;
        t_ridx   d;
    } t_uop;

    typedef struct packed {
        logic ready;
        logic rd;
        logic start;
        t_uop uop;
    } t_ctl_cmd;

    typedef struct packed {
        logic  accept;
        logic  done;
        t_prog prog;
    } t_dp_stat;

    function automatic t_word mag(t_word v);
        return v[WORD_BITS-1] ? (t_word'(0) - v) : v;
    endfunction

    function automatic t_uop mk(t_uop_op op, t_ridx a, t_ridx b, t_ridx d);
        t_uop u;
        u.op = op;
        u.a  = a;
        u.b  = b;
        u.d  = d;
        return u;
    endfunction

    // reduced add or subtract of an/ad and bn/bd
    function automatic t_uop addsub_body(logic [3:0] k, t_uop_op op_as);
        t_uop u;
        case (k)
            4'd0:    u = mk(UOP_GCD,  R_AD, R_BD, R_G);
            4'd1:    u = mk(UOP_DIVM, R_BD, R_G,  R_T0);
            4'd2:    u = mk(UOP_MUL,  R_AN, R_T0, R_T0);
            4'd3:    u = mk(UOP_DIVM, R_AD, R_G,  R_T1);
            4'd4:    u = mk(UOP_MUL,  R_BN, R_T1, R_C);
            4'd5:    u = mk(op_as,    R_T0, R_C,  R_C);
            4'd6:    u = mk(UOP_GCD,  R_C,  R_G,  R_G2);
            4'd7:    u = mk(UOP_DIVM, R_C,  R_G2, R_RN);
            4'd8:    u = mk(UOP_DIVM, R_BD, R_G2, R_T0);
            4'd9:    u = mk(UOP_MUL,  R_T0, R_T1, R_RD);
            default: u = mk(UOP_OUT,  R_RN, R_RD, R_RN);
        endcase
        return u;
    endfunction

    // cross-cancelled product of an/ad and bn/bd
    function automatic t_uop muldiv_body(logic [3:0] k, t_ridx bn, t_ridx bd);
        t_uop u;
        case (k)
            4'd0:    u = mk(UOP_GCD,  R_AN, bd,   R_G);
            4'd1:    u = mk(UOP_GCD,  R_AD, bn,   R_G2);
            4'd2:    u = mk(UOP_DIVM, R_AN, R_G,  R_T0);
            4'd3:    u = mk(UOP_DIVM, bn,   R_G2, R_T1);
            4'd4:    u = mk(UOP_MUL,  R_T0, R_T1, R_RN);
            4'd5:    u = mk(UOP_DIVM, R_AD, R_G2, R_T0);
            4'd6:    u = mk(UOP_DIVM, bd,   R_G,  R_T1);
            4'd7:    u = mk(UOP_MUL,  R_T0, R_T1, R_RD);
            default: u = mk(UOP_OUT,  R_RN, R_RD, R_RN);
        endcase
        return u;
    endfunction

    // microprogram store: four loads, then the body of the program
    function automatic t_uop uop_at(t_prog prog, t_pc pc);
        t_uop u;
        t_pc  j;
        j = pc - t_pc'(4);
        if (pc < t_pc'(4)) begin
            u = mk(UOP_LD, t_ridx'(pc), R_AN, t_ridx'(pc));
        end else begin
            case (prog)
                PROG_ADD: u = addsub_body(j[3:0], UOP_ADD);
                PROG_SUB: u = addsub_body(j[3:0], UOP_SUB);
                PROG_MUL: u = muldiv_body(j[3:0], R_BN, R_BD);
                PROG_DIV: begin
                    if (j == t_pc'(0))
                        u = mk(UOP_CNEG, R_AN, R_BN, R_AN);
                    else if (j == t_pc'(1))
                        u = mk(UOP_CNEG, R_BN, R_BN, R_BN);
                    else
                        u = muldiv_body(4'(j - t_pc'(2)), R_BD, R_BN);
                end
                PROG_MOD: begin
                    if (j == t_pc'(0))
                        u = mk(UOP_MUL, R_AN, R_BD, R_T0);
                    else if (j == t_pc'(1))
                        u = mk(UOP_MUL, R_AD, R_BN, R_T1);
                    else if (j == t_pc'(2))
                        u = mk(UOP_SDIV, R_T0, R_T1, R_Q);
                    else if (j == t_pc'(3))
                        u = mk(UOP_MUL, R_BN, R_Q, R_BN);
                    else
                        u = addsub_body(4'(j - t_pc'(4)), UOP_SUB);
                end
                PROG_NEG: begin
                    if (j == t_pc'(0))
                        u = mk(UOP_NEG, R_AN, R_AN, R_RN);
                    else
                        u = mk(UOP_OUT, R_RN, R_AD, R_RN);
                end
                PROG_NOT: begin
                    if (j == t_pc'(0))
                        u = mk(UOP_NOT, R_AN, R_AN, R_RN);
                    else if (j == t_pc'(1))
                        u = mk(UOP_SET1, R_AN, R_AN, R_RD);
                    else
                        u = mk(UOP_OUT, R_RN, R_RD, R_RN);
                end
                PROG_DZ: begin
                    if (j == t_pc'(0))
                        u = mk(UOP_SET0, R_AN, R_AN, R_RN);
                    else
                        u = mk(UOP_OUT, R_RN, R_RN, R_RN);
                end
                default: begin
                    if (j == t_pc'(0))
                        u = mk(UOP_SET0, R_AN, R_AN, R_RN);
                    else if (j == t_pc'(1))
                        u = mk(UOP_SET1, R_AN, R_AN, R_RD);
                    else
                        u = mk(UOP_OUT, R_RN, R_RD, R_RN);
                end
            endcase
        end
        return u;
    endfunction

endpackage

// ----- rtl/rau_in_if.sv -----
interface rau_in_if;
    logic                  valid;
    logic                  ready;
    logic [2:0]            cmd;
    logic signed [rau_pkg::WORD_BITS-1:0] a_num;
    logic signed [rau_pkg::WORD_BITS-1:0] a_den;
    logic signed [rau_pkg::WORD_BITS-1:0] b_num;
    logic signed [rau_pkg::WORD_BITS-1:0] b_den;

    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

// ----- rtl/rau_out_if.sv -----
interface rau_out_if;
    logic                  valid;
    logic                  ready;
    logic signed [rau_pkg::WORD_BITS-1:0] res_num;
    logic signed [rau_pkg::WORD_BITS-1:0] res_den;
    logic                  div_zero;

    modport source (output valid, res_num, res_den, div_zero, input ready);
    modport sink   (input valid, res_num, res_den, div_zero, output ready);
endinterface

// ----- rtl/rau_ctl.sv -----
module rau_ctl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_dp_stat i_stat,
    output rau_pkg::t_ctl_cmd o_cmd
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_pc    r_pc, n_pc;
    t_uop   uop;

    assign uop = uop_at(i_stat.prog, r_pc);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            S_IDLE: begin
                if (i_stat.accept) begin
                    n_state = S_READ;
                    n_pc    = '0;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC, S_WAIT: begin
                if (i_stat.done) begin
                    if (uop.op == UOP_OUT) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_READ;
                        n_pc    = r_pc + t_pc'(1);
                    end
                end else begin
                    n_state = S_WAIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_cmd.ready = (r_state == S_IDLE);
    assign o_cmd.rd    = (r_state == S_READ);
    assign o_cmd.start = (r_state == S_EXEC);
    assign o_cmd.uop   = uop;

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.accept |-> r_state == S_IDLE)
        else $error("request taken outside idle");
    a_done_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_state == S_EXEC)
        else $error("operand read not followed by execute");
    a_out_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC || r_state == S_WAIT) && i_stat.done && uop.op == UOP_OUT)
        |=> r_state == S_IDLE)
        else $error("item did not finish after output");
endmodule

// ----- rtl/rau_dp.sv -----
module rau_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_ctl_cmd i_cmd,
    output rau_pkg::t_dp_stat o_stat,
    rau_in_if.sink            i_in,
    rau_out_if.source         o_out
);
    import rau_pkg::*;

    t_word      r_rf [REGS];
    t_word      r_opa, r_opb;
    t_word      r_in_an, r_in_ad, r_in_bn, r_in_bd;
    logic [2:0] r_cmd;
    logic       r_busy, n_busy;
    t_word      r_x, r_y, r_z, n_x, n_y, n_z;
    logic [6:0] r_cnt, n_cnt;
    logic       r_neg, n_neg;
    logic       r_o_valid, n_o_valid;
    t_word      r_o_num, r_o_den;
    logic       r_o_dz;

    t_uop_op    op;
    logic       accept, done, fin, out_free, dz_case;
    t_word      wr_data, in_sel;
    logic [71:0] pp;
    logic [64:0] trial;
    logic        qb;
    t_word       quo;

    assign op       = i_cmd.uop.op;
    assign accept   = i_in.valid && i_cmd.ready;
    assign out_free = !r_o_valid || o_out.ready;
    assign dz_case  = (r_cmd == CMD_DIV || r_cmd == CMD_MOD) && (r_in_bn == '0);

    assign i_in.ready    = i_cmd.ready;
    assign o_stat.accept = accept;
    assign o_stat.done   = done;
    assign o_stat.prog   = dz_case ? PROG_DZ : t_prog'(r_cmd);

    always_comb begin
        case (i_cmd.uop.a[1:0])
            2'd0:    in_sel = r_in_an;
            2'd1:    in_sel = r_in_ad;
            2'd2:    in_sel = r_in_bn;
            default: in_sel = r_in_bd;
        endcase
    end

    // step logic of the shared units
    assign pp    = r_x * r_y[7:0];
    assign trial = {r_z, r_x[WORD_BITS-1]} - {1'b0, r_y};
    assign qb    = !trial[WORD_BITS];
    assign quo   = {r_x[WORD_BITS-2:0], qb};

    always_comb begin
        n_busy  = r_busy;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        done    = 1'b0;
        fin     = 1'b0;
        wr_data = '0;
        if (i_cmd.start) begin
            n_cnt = '0;
            case (op)
                UOP_LD:   begin done = 1'b1; wr_data = in_sel; end
                UOP_ADD:  begin done = 1'b1; wr_data = r_opa + r_opb; end
                UOP_SUB:  begin done = 1'b1; wr_data = r_opa - r_opb; end
                UOP_NEG:  begin done = 1'b1; wr_data = t_word'(0) - r_opa; end
                UOP_CNEG: begin
                    done    = 1'b1;
                    wr_data = r_opb[WORD_BITS-1] ? (t_word'(0) - r_opa) : r_opa;
                end
                UOP_NOT:  begin done = 1'b1; wr_data = t_word'(r_opa == '0); end
                UOP_SET0: begin done = 1'b1; wr_data = '0; end
                UOP_SET1: begin done = 1'b1; wr_data = t_word'(1); end
                UOP_MUL:  begin
                    n_busy = 1'b1;
                    n_x    = r_opa;
                    n_y    = r_opb;
                    n_z    = '0;
                end
                UOP_GCD:  begin
                    n_busy = 1'b1;
                    n_x    = mag(r_opa);
                    n_y    = mag(r_opb);
                end
                UOP_DIVM: begin
                    if (r_opb == '0) begin
                        done    = 1'b1;
                        wr_data = r_opa;
                    end else begin
                        n_busy = 1'b1;
                        n_x    = mag(r_opa);
                        n_y    = r_opb;
                        n_z    = '0;
                        n_neg  = r_opa[WORD_BITS-1];
                    end
                end
                UOP_SDIV: begin
                    if (mag(r_opb) == '0) begin
                        done    = 1'b1;
                        wr_data = '0;
                    end else begin
                        n_busy = 1'b1;
                        n_x    = mag(r_opa);
                        n_y    = mag(r_opb);
                        n_z    = '0;
                        n_neg  = r_opa[WORD_BITS-1] ^ r_opb[WORD_BITS-1];
                    end
                end
                default:  n_busy = 1'b1;
            endcase
        end else if (r_busy) begin
            n_cnt = r_cnt + 7'd1;
            case (op)
                UOP_MUL: begin
                    n_x     = r_x << 8;
                    n_y     = r_y >> 8;
                    n_z     = r_z + pp[WORD_BITS-1:0];
                    fin     = (r_cnt == 7'd7);
                    wr_data = n_z;
                end
                UOP_GCD: begin
                    n_cnt = r_cnt;
                    if (r_x == '0 || r_y == '0) begin
                        fin     = 1'b1;
                        wr_data = (r_x | r_y) << r_cnt[5:0];
                    end else if (!r_x[0] && !r_y[0]) begin
                        n_x   = r_x >> 1;
                        n_y   = r_y >> 1;
                        n_cnt = r_cnt + 7'd1;
                    end else if (!r_x[0]) begin
                        n_x = r_x >> 1;
                    end else if (!r_y[0]) begin
                        n_y = r_y >> 1;
                    end else if (r_x >= r_y) begin
                        n_x = r_x - r_y;
                    end else begin
                        n_y = r_y - r_x;
                    end
                end
                UOP_DIVM, UOP_SDIV: begin
                    n_z     = qb ? trial[WORD_BITS-1:0]
                                 : {r_z[WORD_BITS-2:0], r_x[WORD_BITS-1]};
                    n_x     = quo;
                    fin     = (r_cnt == 7'(WORD_BITS - 1));
                    wr_data = r_neg ? (t_word'(0) - quo) : quo;
                end
                default: fin = out_free;
            endcase
            if (fin) begin
                done   = 1'b1;
                n_busy = 1'b0;
            end
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (o_out.ready)
            n_o_valid = 1'b0;
        if (fin && op == UOP_OUT)
            n_o_valid = 1'b1;
    end

    // scratch registers: registered two-port read, one write
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_opa <= r_rf[i_cmd.uop.a];
            r_opb <= r_rf[i_cmd.uop.b];
        end
        if (done && op != UOP_OUT)
            r_rf[i_cmd.uop.d] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_in.cmd;
            r_in_an <= i_in.a_num;
            r_in_ad <= i_in.a_den;
            r_in_bn <= i_in.b_num;
            r_in_bd <= i_in.b_den;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        if (fin && op == UOP_OUT) begin
            r_o_num <= r_opa;
            r_o_den <= r_opb;
            r_o_dz  <= dz_case;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.res_num  = r_o_num;
    assign o_out.res_den  = r_o_den;
    assign o_out.div_zero = r_o_dz;

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (i_cmd.start || r_busy))
        else $error("unit finished without work");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && op == UOP_OUT) |-> out_free)
        else $error("result written over a pending one");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("unit started while busy");
endmodule

// ----- rtl/rational_arith_unit_core.sv -----
// each micro-op has its operands read from the scratch registers, is then issued to its unit and
// waits while that unit is busy; multiply, divide and binary gcd are iterative units, and the
// others finish at issue, but the output micro-op waits while the output register is still full
// one request at a time; the next is taken once the current result sits in the output register
// synchronous active-low reset clears the sequencer, unit busy flag and output valid
module rational_arith_unit_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    // command and status between sequencer and datapath
    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    // sequencer walks the microprogram picked by the request's operation
    rau_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (dp_stat),
        .o_cmd   (ctl_cmd)
    );

    // scratch registers, multiplier, divider and gcd unit, output register
    rau_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ctl_cmd),
        .o_stat  (dp_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

// ----- sim/tb_rational_arith_unit_core.sv -----
module tb_rational_arith_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    typedef logic [63:0] t_w64;

    // one result as the block should produce it
    typedef struct {
        t_w64 num;
        t_w64 den;
        logic dz;
    } t_ratio_res;

    // one request
    typedef struct {
        logic [2:0] cmd;
        t_w64       an;
        t_w64       ad;
        t_w64       bn;
        t_w64       bd;
    } t_ratio_req;

    logic i_clk;
    logic i_rst_n;

    rau_in_if  req_ch ();
    rau_out_if res_ch ();

    rational_arith_unit_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch.sink),
        .o_out  (res_ch.source)
    );

    t_ratio_res pending_res[$];
    int         n_errors;
    int         n_reqs;
    int         n_results;
    int         n_dz;
    int         cmd_seen[8];
    bit         stim_done;
    bit         hold_sink;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------------------------
    // arithmetic helpers, all on 64-bit two's complement words
    // ---------------------------------------------------------------------------------

    function automatic t_w64 abs_w(t_w64 x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // euclid on magnitudes; gcd(x,0) = |x|, gcd(0,0) = 0
    function automatic t_w64 gcd_w(t_w64 x, t_w64 y);
        t_w64 p;
        t_w64 q;
        t_w64 t;
        p = abs_w(x);
        q = abs_w(y);
        while (q != 0) begin
            t = p % q;
            p = q;
            q = t;
        end
        return p;
    endfunction

    // signed value over a magnitude; zero divisor passes the value through
    function automatic t_w64 div_mag(t_w64 x, t_w64 g);
        t_w64 q;
        if (g == 0)
            return x;
        q = abs_w(x) / g;
        return x[63] ? (64'd0 - q) : q;
    endfunction

    // truncated signed divide, zero divisor gives zero
    function automatic t_w64 trunc_div(t_w64 x, t_w64 y);
        t_w64 q;
        if (y == 0)
            return 64'd0;
        q = abs_w(x) / abs_w(y);
        return (x[63] != y[63]) ? (64'd0 - q) : q;
    endfunction

    // reduced sum or difference over the denominator gcd
    function automatic void sum_ratio(input t_w64 an, ad, bn, bd, input bit minus,
                                      output t_w64 rn, rd);
        t_w64 g;
        t_w64 ta;
        t_w64 tb;
        t_w64 c;
        t_w64 g2;
        g  = gcd_w(ad, bd);
        ta = an * div_mag(bd, g);
        tb = bn * div_mag(ad, g);
        c  = minus ? ta - tb : ta + tb;
        g2 = gcd_w(c, g);
        rn = div_mag(c, g2);
        rd = div_mag(bd, g2) * div_mag(ad, g);
    endfunction

    // cross-cancelled product; for a quotient the divisor sign moves to the numerator
    function automatic void prod_ratio(input t_w64 an, ad, bn, bd, input bit recip,
                                       output t_w64 rn, rd);
        t_w64 g1;
        t_w64 g2;
        t_w64 t;
        if (recip) begin
            if (bn[63]) begin
                an = 64'd0 - an;
                bn = 64'd0 - bn;
            end
            t  = bn;
            bn = bd;
            bd = t;
        end
        g1 = gcd_w(an, bd);
        g2 = gcd_w(ad, bn);
        rn = div_mag(an, g1) * div_mag(bn, g2);
        rd = div_mag(ad, g2) * div_mag(bd, g1);
    endfunction

    function automatic t_ratio_res rational_result(t_ratio_req r);
        t_ratio_res e;
        t_w64       q;
        e.num = 64'd0;
        e.den = 64'd1;
        e.dz  = 1'b0;
        case (r.cmd)
            CMD_ADD: sum_ratio(r.an, r.ad, r.bn, r.bd, 1'b0, e.num, e.den);
            CMD_SUB: sum_ratio(r.an, r.ad, r.bn, r.bd, 1'b1, e.num, e.den);
            CMD_MUL: prod_ratio(r.an, r.ad, r.bn, r.bd, 1'b0, e.num, e.den);
            CMD_DIV, CMD_MOD: begin
                if (r.bn == 0) begin
                    e.dz  = 1'b1;
                    e.den = 64'd0;
                end else if (r.cmd == CMD_DIV) begin
                    prod_ratio(r.an, r.ad, r.bn, r.bd, 1'b1, e.num, e.den);
                end else begin
                    q = trunc_div(r.an * r.bd, r.ad * r.bn);
                    sum_ratio(r.an, r.ad, r.bn * q, r.bd, 1'b1, e.num, e.den);
                end
            end
            CMD_NEG: begin
                e.num = 64'd0 - r.an;
                e.den = r.ad;
            end
            CMD_NOT: e.num = (r.an == 0) ? 64'd1 : 64'd0;
            default: ;
        endcase
        return e;
    endfunction

    // ---------------------------------------------------------------------------------
    // directed rows: expected value given only where it is obvious
    // ---------------------------------------------------------------------------------

    localparam t_w64 MAXP = 64'h7fff_ffff_ffff_ffff;
    localparam t_w64 MINN = 64'h8000_0000_0000_0000;
    localparam t_w64 ALL1 = 64'hffff_ffff_ffff_ffff;

    typedef struct {
        t_ratio_req req;
        bit         typed;
        t_ratio_res res;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic void add_row(logic [2:0] c, t_w64 an, ad, bn, bd,
                                    bit typed = 1'b0, t_w64 rn = 0, t_w64 rd = 0,
                                    logic dz = 1'b0);
        t_dir_row row;
        row.req   = '{c, an, ad, bn, bd};
        row.typed = typed;
        row.res   = '{rn, rd, dz};
        dir_rows.push_back(row);
    endfunction

    function automatic void build_dir_rows();
        add_row(CMD_ADD, 1, 2, 1, 3);
        add_row(CMD_SUB, 1, 2, 1, 2);
        add_row(CMD_ADD, MAXP, 1, 1, 1);
        add_row(CMD_ADD, 0, 0, 0, 0);                 // all-zero gcd
        add_row(CMD_SUB, MINN, MINN, MINN, MINN);
        add_row(CMD_MUL, 2, 3, 9, 4);
        add_row(CMD_MUL, MINN, ALL1, MAXP, MINN);
        add_row(CMD_MUL, 0, 0, 5, 0);
        add_row(CMD_DIV, 1, 2, -3, 4);                // divisor sign moves over
        add_row(CMD_DIV, MINN, 1, ALL1, 1);           // most negative over minus one
        add_row(CMD_DIV, 7, 3, 0, 5, 1'b1, 0, 0, 1'b1);
        add_row(CMD_DIV, MAXP, MINN, 0, ALL1, 1'b1, 0, 0, 1'b1);
        add_row(CMD_MOD, 7, 1, 2, 1);
        add_row(CMD_MOD, -7, 2, 3, 5);
        add_row(CMD_MOD, 1, 64'h1_0000_0000, 64'h1_0000_0000, 1); // divisor wraps to zero
        add_row(CMD_MOD, 5, 1, 0, 1, 1'b1, 0, 0, 1'b1);
        add_row(CMD_NEG, MINN, 3, 0, 0, 1'b1, MINN, 3);
        add_row(CMD_NEG, MAXP, ALL1, ALL1, ALL1, 1'b1, MINN + 1, ALL1);
        add_row(CMD_NEG, 0, 0, 1, 1, 1'b1, 0, 0);
        add_row(CMD_NOT, 0, 9, 4, 4, 1'b1, 1, 1);
        add_row(CMD_NOT, MINN, 0, 0, 0, 1'b1, 0, 1);
        add_row(CMD_NOT, ALL1, ALL1, MAXP, MINN, 1'b1, 0, 1);
        add_row(3'd7, MAXP, MAXP, MAXP, MAXP, 1'b1, 0, 1);   // unused command
        add_row(3'd7, 0, 0, 0, 0, 1'b1, 0, 1);
    endfunction

    // ---------------------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------------------

    task automatic report_mismatch(string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    int wait_len;
    logic sink_rdy;

    // random stalls on the result side, with a forced long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_rdy <= 1'b0;
            wait_len <= 0;
        end else if (hold_sink) begin
            sink_rdy <= 1'b0;
        end else if (wait_len > 0) begin
            wait_len <= wait_len - 1;
            sink_rdy <= 1'b0;
        end else begin
            sink_rdy <= 1'b1;
            if ($urandom_range(0, 9) < 2)
                wait_len <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                        : $urandom_range(1, 4);
        end
    end

    assign res_ch.ready = sink_rdy;

    always @(posedge i_clk) begin
        t_ratio_res e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (pending_res.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                e = pending_res.pop_front();
                if (res_ch.div_zero)
                    n_dz++;
                if (res_ch.res_num !== e.num)
                    report_mismatch($sformatf("res_num %h, want %h", res_ch.res_num, e.num));
                if (res_ch.res_den !== e.den)
                    report_mismatch($sformatf("res_den %h, want %h", res_ch.res_den, e.den));
                if (res_ch.div_zero !== e.dz)
                    report_mismatch($sformatf("div_zero %b, want %b", res_ch.div_zero, e.dz));
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------------------

    // put one request on the channel and hold it until it is taken
    task automatic send_request(t_ratio_req r, bit typed, t_ratio_res want);
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= r.cmd;
        req_ch.a_num <= r.an;
        req_ch.a_den <= r.ad;
        req_ch.b_num <= r.bn;
        req_ch.b_den <= r.bd;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        pending_res.push_back(typed ? want : rational_result(r));
        cmd_seen[r.cmd]++;
        n_reqs++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // random word: mostly small, sometimes full width or an edge value
    function automatic t_w64 pick_word();
        case ($urandom_range(0, 9))
            0, 1:    return {$urandom, $urandom};
            2:       return MINN;
            3:       return MAXP;
            4:       return 64'd0;
            5:       return 64'(signed'($urandom_range(0, 2000)) - 1000) << $urandom_range(0, 40);
            default: return 64'(signed'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic t_ratio_req pick_req();
        t_ratio_req r;
        r.cmd = ($urandom_range(0, 30) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        r.an  = pick_word();
        r.ad  = pick_word();
        r.bn  = pick_word();
        r.bd  = pick_word();
        // keep most denominators non-zero so the arithmetic is exercised
        if (r.ad == 0 && $urandom_range(0, 3) != 0) r.ad = 1;
        if (r.bd == 0 && $urandom_range(0, 3) != 0) r.bd = 1;
        return r;
    endfunction

    initial begin
        t_ratio_res none;
        n_errors  = 0;
        n_reqs    = 0;
        n_results = 0;
        n_dz      = 0;
        stim_done = 1'b0;
        hold_sink = 1'b0;
        none      = '{0, 0, 1'b0};
        foreach (cmd_seen[k]) cmd_seen[k] = 0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd   <= CMD_ADD;
        req_ch.a_num <= '0;
        req_ch.a_den <= '0;
        req_ch.b_num <= '0;
        req_ch.b_den <= '0;
        build_dir_rows();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
            idle_gap();
        end

        for (int k = 0; k < 380; k++) begin
            // long hold on the result side while requests keep coming
            if (k == 60)
                hold_sink = 1'b1;
            if (k == 64)
                hold_sink = 1'b0;
            // sender pauses until everything has drained
            if (k == 200) begin
                req_ch.valid <= 1'b0;
                while (pending_res.size() != 0)
                    @(posedge i_clk);
            end
            send_request(pick_req(), 1'b0, none);
            idle_gap();
        end
        req_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // releases the long hold by cycle count in case the block stalls its input first
    initial begin
        wait (hold_sink);
        repeat (3000) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // end of run
    // ---------------------------------------------------------------------------------

    initial begin
        wait (stim_done);
        while (pending_res.size() != 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        $display("run covered %0d requests, %0d results, %0d zero divisor cases",
                 n_reqs, n_results, n_dz);
        $display("per command: add %0d sub %0d mul %0d div %0d mod %0d neg %0d not %0d other %0d",
                 cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3],
                 cmd_seen[4], cmd_seen[5], cmd_seen[6], cmd_seen[7]);
        if (n_errors == 0 && pending_res.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // worst case: the longest request plus stalls, 404 requests, several times over
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
